// ===== design/scfl_pkg.sv =====
// ----------------------------------------------------------------------------
// scfl_pkg: shared types and constants of the staged config frame loader
// Frame marker bytes, command codes, the command record passed from the
// parser to the reply engine, and the record of one packed reply word.
// ----------------------------------------------------------------------------
package scfl_pkg;

  // Frame markers
  localparam logic [7:0] SOF_A = 8'hBB;
  localparam logic [7:0] SOF_B = 8'hCC;
  localparam logic [7:0] END_A = 8'hDD;
  localparam logic [7:0] END_B = 8'hEE;

  // Command codes
  localparam logic [7:0] OP_WRITE  = 8'h01;
  localparam logic [7:0] OP_COMMIT = 8'h02;
  localparam logic [7:0] OP_ABORT  = 8'h03;
  localparam logic [7:0] OP_READ   = 8'h04;

  // Timeout register value after reset
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Queue depths (powers of two)
  localparam int CMDQ_DEPTH = 2;
  localparam int OQ_DEPTH   = 2;

  // One reply to build
  typedef struct packed {
    logic [7:0] op;        // command code echoed in the reply
    logic       has_data;  // reply carries a whole bank
    logic       bank;      // bank to send
    logic       zero;      // bank was never written: send zeros
    logic       pulse;     // commit applied staged data
  } cmd_t;

  // One packed reply word
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        pulse;
  } out_item_t;

endpackage

// ===== design/scfl_front.sv =====
// ----------------------------------------------------------------------------
// scfl_front: frame parser
// Accepts link bytes and timer ticks, tracks the frame state, writes WRITE
// payload bytes into the staging bank and queues one reply request per good
// frame. Owns the timeout register, the bank select and the staged flag.
// ----------------------------------------------------------------------------
module scfl_front #(
  parameter int PAYLOAD_BYTES = 224
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [15:0]                          cfg_wdata,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 in_mode,
  input  logic [7:0]                           in_rx_byte,
  input  logic                                 back_quiet,
  input  logic                                 cmdq_full,
  output logic                                 cmdq_push,
  output scfl_pkg::cmd_t                       cmdq_din,
  output logic                                 wr_en,
  output logic [$clog2(2*PAYLOAD_BYTES)-1:0]   wr_addr,
  output logic [7:0]                           wr_data
);
  import scfl_pkg::*;

  localparam int IW = $clog2(PAYLOAD_BYTES + 1);
  localparam int AW = $clog2(2 * PAYLOAD_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SOF_B   = 6'b000010,
    ST_CMD     = 6'b000100,
    ST_PAYLOAD = 6'b001000,
    ST_END_A   = 6'b010000,
    ST_END_B   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      cur_cmd_r, cur_cmd_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [7:0]      first_end_r, first_end_nxt;
  logic [15:0]     ticks_r, ticks_nxt;
  logic [15:0]     timeout_r;
  logic            active_r, active_nxt;
  logic            staged_r, staged_nxt;
  logic            bank0_zero_r, bank0_zero_nxt;
  logic            accept;
  logic [15:0]     ticks_inc;
  logic            stage_bank;

  // Stall on a full request queue, and hold payload bytes while a reply reads
  assign full   = cmdq_full | ((state_r == ST_PAYLOAD) & ~back_quiet);
  assign accept = push & ~full;

  assign stage_bank = ~active_r;
  assign ticks_inc  = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;

  // Payload write port
  assign wr_data = in_rx_byte;
  assign wr_addr = stage_bank ? (AW'(PAYLOAD_BYTES) + AW'(idx_r)) : AW'(idx_r);

  // Parse one request
  always_comb begin
    state_nxt      = state_r;
    cur_cmd_nxt    = cur_cmd_r;
    idx_nxt        = idx_r;
    first_end_nxt  = first_end_r;
    ticks_nxt      = ticks_r;
    active_nxt     = active_r;
    staged_nxt     = staged_r;
    bank0_zero_nxt = bank0_zero_r;
    cmdq_push      = 1'b0;
    cmdq_din       = '0;
    wr_en          = 1'b0;
    if (accept) begin
      if (in_mode) begin
        if (state_r != ST_IDLE) begin
          if (ticks_inc >= timeout_r) begin
            state_nxt  = ST_IDLE;
            ticks_nxt  = '0;
            idx_nxt    = '0;
            staged_nxt = 1'b0;
          end else begin
            ticks_nxt = ticks_inc;
          end
        end
      end else begin
        ticks_nxt = '0;
        unique case (state_r)
          ST_IDLE: begin
            if (in_rx_byte == SOF_A) state_nxt = ST_SOF_B;
          end
          ST_SOF_B: begin
            if (in_rx_byte == SOF_B) begin
              state_nxt = ST_CMD;
            end else begin
              state_nxt = ST_IDLE;
              idx_nxt   = '0;
            end
          end
          ST_CMD: begin
            cur_cmd_nxt = in_rx_byte;
            idx_nxt     = '0;
            if (in_rx_byte == OP_WRITE) begin
              state_nxt = ST_PAYLOAD;
            end else if (in_rx_byte == OP_COMMIT || in_rx_byte == OP_ABORT ||
                         in_rx_byte == OP_READ) begin
              state_nxt = ST_END_A;
            end else begin
              state_nxt  = ST_IDLE;
              staged_nxt = 1'b0;
            end
          end
          ST_PAYLOAD: begin
            wr_en   = 1'b1;
            idx_nxt = idx_r + IW'(1);
            if (!stage_bank) bank0_zero_nxt = 1'b0;
            if (idx_r == IW'(PAYLOAD_BYTES - 1)) state_nxt = ST_END_A;
          end
          ST_END_A: begin
            first_end_nxt = in_rx_byte;
            state_nxt     = ST_END_B;
          end
          ST_END_B: begin
            state_nxt = ST_IDLE;
            idx_nxt   = '0;
            if (first_end_r != END_A || in_rx_byte != END_B) begin
              staged_nxt = 1'b0;
            end else begin
              cmdq_din.op = cur_cmd_r;
              priority if (cur_cmd_r == OP_WRITE) begin
                staged_nxt        = 1'b1;
                cmdq_push         = 1'b1;
                cmdq_din.has_data = 1'b1;
                cmdq_din.bank     = stage_bank;
                cmdq_din.zero     = ~stage_bank & bank0_zero_r;
              end else if (cur_cmd_r == OP_COMMIT) begin
                cmdq_push      = 1'b1;
                cmdq_din.pulse = staged_r;
                if (staged_r) begin
                  active_nxt = ~active_r;
                  staged_nxt = 1'b0;
                end
              end else if (cur_cmd_r == OP_ABORT) begin
                cmdq_push  = 1'b1;
                staged_nxt = 1'b0;
              end else if (cur_cmd_r == OP_READ) begin
                cmdq_push         = 1'b1;
                cmdq_din.has_data = 1'b1;
                cmdq_din.bank     = active_r;
                cmdq_din.zero     = ~active_r & bank0_zero_r;
              end else begin
                cmdq_push = 1'b0;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
            idx_nxt   = '0;
          end
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_cmd_r    <= '0;
      idx_r        <= '0;
      first_end_r  <= '0;
      ticks_r      <= '0;
      timeout_r    <= TIMEOUT_RESET;
      active_r     <= 1'b0;
      staged_r     <= 1'b0;
      bank0_zero_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      cur_cmd_r    <= cur_cmd_nxt;
      idx_r        <= idx_nxt;
      first_end_r  <= first_end_nxt;
      ticks_r      <= ticks_nxt;
      active_r     <= active_nxt;
      staged_r     <= staged_nxt;
      bank0_zero_r <= bank0_zero_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
  end

endmodule

// ===== design/scfl_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// scfl_cmd_fifo: reply request queue
// Short queue between the parser and the reply engine so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module scfl_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  scfl_pkg::cmd_t  din,
  output logic            q_full,
  input  logic            rd_en,
  output scfl_pkg::cmd_t  dout,
  output logic            q_empty
);
  import scfl_pkg::*;

  localparam int PTRW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW   = $clog2(CMDQ_DEPTH + 1);

  cmd_t            slot_r [CMDQ_DEPTH];
  logic [PTRW-1:0] wptr_r, rptr_r;
  logic [CW-1:0]   num_r;
  logic            do_wr, do_rd;

  assign q_full  = (num_r == CW'(CMDQ_DEPTH));
  assign q_empty = (num_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign dout    = slot_r[rptr_r];

  // Store requests
  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wptr_r] <= din;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      num_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + PTRW'(1);
      if (do_rd) rptr_r <= rptr_r + PTRW'(1);
      num_r <= num_r + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

// ===== design/scfl_back.sv =====
// ----------------------------------------------------------------------------
// scfl_back: reply engine
// Holds the two-bank payload memory. Takes one reply request at a time,
// walks its frame one byte a cycle while the output queue has room (bank
// bytes from the read port), packs 8 bytes per word into the output queue.
// ----------------------------------------------------------------------------
module scfl_back #(
  parameter int PAYLOAD_BYTES = 224
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [$clog2(2*PAYLOAD_BYTES)-1:0]  wr_addr,
  input  logic [7:0]                          wr_data,
  input  logic                                cmdq_empty,
  input  scfl_pkg::cmd_t                      cmdq_head,
  output logic                                cmdq_pop,
  output logic                                busy,
  output logic                                empty,
  input  logic                                pop,
  output logic [63:0]                         out_tx_data,
  output logic [3:0]                          out_tx_count,
  output logic                                out_tx_last,
  output logic                                out_commit_pulse
);
  import scfl_pkg::*;

  localparam int AW    = $clog2(2 * PAYLOAD_BYTES);
  localparam int PW    = $clog2(PAYLOAD_BYTES + 5);
  localparam int OPW   = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OCW   = $clog2(OQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_DATA   = PW'(PAYLOAD_BYTES + 4);
  localparam logic [PW-1:0] LAST_NODATA = PW'(4);

  logic [7:0]      mem [2*PAYLOAD_BYTES];
  logic [7:0]      rdata_r;

  // Issue stage
  logic            act_r;
  cmd_t            cmd_r;
  logic [PW-1:0]   pos_r;
  logic            can_issue;
  logic [PW-1:0]   last_pos;
  logic [PW-1:0]   dix;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      fix_byte;
  logic            is_mem;

  // Pack stage
  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_mem_r;
  logic            s1_zero_r;
  logic            s1_last_r;
  logic            s1_pulse_r;
  logic [2:0]      wcnt_r;
  logic [63:0]     word_r;
  logic            wpulse_r;
  logic [7:0]      s1_b;
  logic [63:0]     word_new;
  logic            pulse_word;
  logic            oq_push;
  out_item_t       oq_in;

  // Output queue
  out_item_t       oq_r [OQ_DEPTH];
  logic [OPW-1:0]  oq_wptr_r, oq_rptr_r;
  logic [OCW-1:0]  oq_num_r;
  logic            oq_pop;

  assign busy      = act_r;
  assign cmdq_pop  = ~act_r & ~cmdq_empty;
  assign can_issue = act_r & ((oq_num_r + OCW'(s1_valid_r)) < OCW'(OQ_DEPTH));
  assign last_pos  = cmd_r.has_data ? LAST_DATA : LAST_NODATA;
  assign dix       = pos_r - PW'(3);
  assign rd_addr   = cmd_r.bank ? (AW'(PAYLOAD_BYTES) + AW'(dix)) : AW'(dix);

  // Pick the frame byte at this position
  always_comb begin
    is_mem   = 1'b0;
    fix_byte = '0;
    priority if (pos_r == PW'(0)) begin
      fix_byte = SOF_A;
    end else if (pos_r == PW'(1)) begin
      fix_byte = SOF_B;
    end else if (pos_r == PW'(2)) begin
      fix_byte = cmd_r.op;
    end else if (pos_r == last_pos) begin
      fix_byte = END_B;
    end else if (pos_r == last_pos - PW'(1)) begin
      fix_byte = END_A;
    end else begin
      is_mem = 1'b1;
    end
  end

  // Payload memory: write from the parser, read for replies
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (can_issue) rdata_r <= mem[rd_addr];
  end

  // Load a request and walk its frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= can_issue;
      if (cmdq_pop) begin
        act_r <= 1'b1;
      end else if (can_issue && pos_r == last_pos) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmdq_pop) begin
      cmd_r <= cmdq_head;
      pos_r <= '0;
    end else if (can_issue) begin
      pos_r <= pos_r + PW'(1);
    end
    if (can_issue) begin
      s1_byte_r  <= fix_byte;
      s1_mem_r   <= is_mem;
      s1_zero_r  <= cmd_r.zero;
      s1_last_r  <= (pos_r == last_pos);
      s1_pulse_r <= cmd_r.pulse & (pos_r == PW'(0));
    end
  end

  // Pack bytes into words, first byte in the low bits
  always_comb begin
    s1_b       = s1_mem_r ? (s1_zero_r ? 8'h00 : rdata_r) : s1_byte_r;
    word_new   = (wcnt_r == 3'd0) ? 64'd0 : word_r;
    word_new[{wcnt_r, 3'b000} +: 8] = s1_b;
    pulse_word = (wcnt_r == 3'd0) ? s1_pulse_r : wpulse_r;
    oq_push    = s1_valid_r & ((wcnt_r == 3'd7) | s1_last_r);
    oq_in.data  = word_new;
    oq_in.count = {1'b0, wcnt_r} + 4'd1;
    oq_in.last  = s1_last_r;
    oq_in.pulse = pulse_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
    end else if (s1_valid_r) begin
      wcnt_r <= oq_push ? 3'd0 : wcnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      word_r   <= word_new;
      wpulse_r <= pulse_word;
    end
  end

  // Output queue
  assign empty            = (oq_num_r == '0);
  assign oq_pop           = pop & ~empty;
  assign out_tx_data      = oq_r[oq_rptr_r].data;
  assign out_tx_count     = oq_r[oq_rptr_r].count;
  assign out_tx_last      = oq_r[oq_rptr_r].last;
  assign out_commit_pulse = oq_r[oq_rptr_r].pulse;

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wptr_r] <= oq_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_num_r  <= '0;
    end else begin
      if (oq_push) oq_wptr_r <= oq_wptr_r + OPW'(1);
      if (oq_pop)  oq_rptr_r <= oq_rptr_r + OPW'(1);
      oq_num_r <= oq_num_r + OCW'(oq_push) - OCW'(oq_pop);
    end
  end

endmodule

// ===== design/staged_config_frame_loader_top.sv =====
// ----------------------------------------------------------------------------
// staged_config_frame_loader_top: staged configuration frame loader
//
//   Channel  Handshake        Payload
//   -------  ---------------  --------------------------------------------
//   input    push / full      in_mode, in_rx_byte
//   result   empty / pop      out_tx_data, out_tx_count, out_tx_last,
//                             out_commit_pulse
//   config   cfg_we           cfg_wdata (byte timeout in ticks)
//
// A byte or tick request is taken whenever push is high and full is low.
// A reply walks its frame one byte per cycle through the payload memory
// read port while the output queue has room; an ack frame is 5 bytes, an
// echo or read frame PAYLOAD_BYTES+5 bytes (229 at 224 payload bytes).
// WRITE payload bytes are held off (full high) while a reply is still queued
// or being walked; every request is held off while the request queue is full.
// Reset is synchronous; the inactive bank is not cleared.
// ----------------------------------------------------------------------------
module staged_config_frame_loader_top #(
  parameter int PAYLOAD_BYTES = 224
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_tx_data,
  output logic [3:0]  out_tx_count,
  output logic        out_tx_last,
  output logic        out_commit_pulse
);
  import scfl_pkg::*;

  localparam int AW = $clog2(2 * PAYLOAD_BYTES);

  logic           cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
  cmd_t           cmdq_din, cmdq_head;
  logic           back_busy, back_quiet;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;

  assign back_quiet = cmdq_empty & ~back_busy;

  // Parser
  scfl_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .full       (full),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .back_quiet (back_quiet),
    .cmdq_full  (cmdq_full),
    .cmdq_push  (cmdq_push),
    .cmdq_din   (cmdq_din),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Request queue
  scfl_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmdq_push),
    .din     (cmdq_din),
    .q_full  (cmdq_full),
    .rd_en   (cmdq_pop),
    .dout    (cmdq_head),
    .q_empty (cmdq_empty)
  );

  // Reply engine
  scfl_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .cmdq_empty       (cmdq_empty),
    .cmdq_head        (cmdq_head),
    .cmdq_pop         (cmdq_pop),
    .busy             (back_busy),
    .empty            (empty),
    .pop              (pop),
    .out_tx_data      (out_tx_data),
    .out_tx_count     (out_tx_count),
    .out_tx_last      (out_tx_last),
    .out_commit_pulse (out_commit_pulse)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the staged config frame loader
// Feeds link bytes and timer ticks as frames (write, commit, abort, read,
// and broken ones), predicts every packed reply word from a local model of
// the parser and both banks, and checks each popped word field by field.
// ----------------------------------------------------------------------------
module tb;
  import scfl_pkg::*;

  localparam int PB              = 224;
  localparam int POP_HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = PB + 16;

  typedef enum logic [2:0] {
    PS_IDLE, PS_SOF_B, PS_CMD, PS_PAYLOAD, PS_END_A, PS_END_B
  } parse_t;

  // One directed request, with an optional hand-written reply word
  typedef struct packed {
    logic      mode;
    logic [7:0] rx;
    logic      typed;
    out_item_t word;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        push;
  logic        full;
  logic        in_mode;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic [63:0] out_tx_data;
  logic [3:0]  out_tx_count;
  logic        out_tx_last;
  logic        out_commit_pulse;

  // Loader model state
  logic [15:0] timeout_lim;
  logic [7:0]  bank_mem [2*PB];
  bit          live_bank;
  bit          staged;
  parse_t      parse_st;
  logic [7:0]  cur_op;
  int          pay_idx;
  logic [7:0]  end_a_byte;
  logic [15:0] tick_cnt;

  out_item_t   fresh_words [$];
  out_item_t   reply_words [$];
  script_row_t script [28];

  int          word_errors = 0;
  int          items_fed;
  int          cyc = 0;
  int          stuck_cycles;
  bit          hold_pop_req;

  staged_config_frame_loader_top #(.PAYLOAD_BYTES(PB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_tx_data      (out_tx_data),
    .out_tx_count     (out_tx_count),
    .out_tx_last      (out_tx_last),
    .out_commit_pulse (out_commit_pulse)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Both sides run without gaps inside this window
  function automatic bit steady_window();
    return cyc >= 800 && cyc < 2300;
  endfunction

  // ---------------------------------------------------------------- model
  function automatic void abandon_frame(input bit clear_staged);
    parse_st = PS_IDLE;
    tick_cnt = '0;
    pay_idx  = 0;
    if (clear_staged) staged = 1'b0;
  endfunction

  // Build BB CC op [bank] DD EE and pack it eight bytes per word
  function automatic void queue_reply(input logic [7:0] op, input bit with_bank,
                                      input bit bk, input bit pulse);
    logic [7:0] frame [$];
    out_item_t  w;
    frame = {SOF_A, SOF_B, op};
    if (with_bank) begin
      for (int i = 0; i < PB; i++) frame.push_back(bank_mem[int'(bk) * PB + i]);
    end
    frame.push_back(END_A);
    frame.push_back(END_B);
    for (int i = 0; i < frame.size(); i += 8) begin
      w = '0;
      for (int k = 0; k < 8 && i + k < frame.size(); k++) begin
        w.data[8*k +: 8] = frame[i + k];
        w.count = 4'(k + 1);
      end
      w.last  = (i + 8 >= frame.size());
      w.pulse = pulse && (i == 0);
      fresh_words.push_back(w);
    end
  endfunction

  // Advance the loader by one request; reply words land in fresh_words
  function automatic void advance_loader(input logic m, input logic [7:0] b);
    bit applied;
    fresh_words.delete();
    if (m) begin
      if (parse_st == PS_IDLE) return;
      if (tick_cnt != 16'hFFFF) tick_cnt++;
      if (tick_cnt >= timeout_lim) abandon_frame(1'b1);
      return;
    end
    tick_cnt = '0;
    case (parse_st)
      PS_IDLE: if (b == SOF_A) parse_st = PS_SOF_B;
      PS_SOF_B: begin
        if (b == SOF_B) parse_st = PS_CMD;
        else abandon_frame(1'b0);
      end
      PS_CMD: begin
        cur_op  = b;
        pay_idx = 0;
        if (b == OP_WRITE) parse_st = PS_PAYLOAD;
        else if (b == OP_COMMIT || b == OP_ABORT || b == OP_READ) parse_st = PS_END_A;
        else abandon_frame(1'b1);
      end
      PS_PAYLOAD: begin
        // Payload goes to the bank that is not live
        bank_mem[(live_bank ? 0 : PB) + pay_idx] = b;
        pay_idx++;
        if (pay_idx >= PB) parse_st = PS_END_A;
      end
      PS_END_A: begin
        end_a_byte = b;
        parse_st   = PS_END_B;
      end
      PS_END_B: begin
        if (end_a_byte != END_A || b != END_B) begin
          abandon_frame(1'b1);
        end else begin
          abandon_frame(1'b0);
          case (cur_op)
            OP_WRITE: begin
              staged = 1'b1;
              queue_reply(OP_WRITE, 1'b1, ~live_bank, 1'b0);
            end
            OP_COMMIT: begin
              applied = staged;
              if (staged) begin
                live_bank = ~live_bank;
                staged    = 1'b0;
              end
              queue_reply(OP_COMMIT, 1'b0, 1'b0, applied);
            end
            OP_ABORT: begin
              staged = 1'b0;
              queue_reply(OP_ABORT, 1'b0, 1'b0, 1'b0);
            end
            OP_READ: queue_reply(OP_READ, 1'b1, live_bank, 1'b0);
            default: ;
          endcase
        end
      end
      default: abandon_frame(1'b0);
    endcase
  endfunction

  // ------------------------------------------------------------- requests
  // Offer one request and hold it until the block takes it
  task automatic send_item(input logic m, input logic [7:0] b);
    while (!steady_window() && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_mode    <= m;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic feed(input logic m, input logic [7:0] b);
    send_item(m, b);
    advance_loader(m, b);
    foreach (fresh_words[j]) reply_words.push_back(fresh_words[j]);
    items_fed++;
  endtask

  // Send a frame byte, sometimes after a few ticks that stay below the timeout
  task automatic frame_byte(input logic [7:0] b);
    int n;
    n = int'(timeout_lim) - 1;
    if (n > 3) n = 3;
    if (n >= 1 && $urandom_range(9) == 0) begin
      repeat ($urandom_range(n, 1)) feed(1'b1, 8'($urandom_range(255)));
    end
    feed(1'b0, b);
  endtask

  task automatic feed_frame(input logic [7:0] op, input bit with_payload,
                            input logic [7:0] e0, input logic [7:0] e1);
    frame_byte(SOF_A);
    frame_byte(SOF_B);
    frame_byte(op);
    if (with_payload) repeat (PB) frame_byte(8'($urandom_range(255)));
    frame_byte(e0);
    frame_byte(e1);
  endtask

  function automatic logic [7:0] pick_short_op();
    case ($urandom_range(2))
      0:       return OP_COMMIT;
      1:       return OP_ABORT;
      default: return OP_READ;
    endcase
  endfunction

  // Random frames, mostly well formed, until stop_at requests have gone in
  task automatic run_frames(input int stop_at, input bit with_timeouts);
    int         kind;
    int         depth;
    logic [7:0] c;
    logic [7:0] op;
    logic [7:0] e0;
    logic [7:0] e1;
    while (items_fed < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 6 && stop_at - items_fed > PB + 16) begin
        // full write frame, only where the request budget has room for it
        e1 = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : END_B;
        feed_frame(OP_WRITE, 1'b1, END_A, e1);
      end else if (kind < 28) begin
        feed_frame(OP_COMMIT, 1'b0, END_A, END_B);
      end else if (kind < 42) begin
        feed_frame(OP_ABORT, 1'b0, END_A, END_B);
      end else if (kind < 60) begin
        feed_frame(OP_READ, 1'b0, END_A, END_B);
      end else if (kind < 67) begin
        // wrong second start byte
        do c = 8'($urandom_range(255)); while (c == SOF_B);
        frame_byte(SOF_A);
        frame_byte(c);
      end else if (kind < 74) begin
        // unknown command
        do c = 8'($urandom_range(255)); while (c >= OP_WRITE && c <= OP_READ);
        frame_byte(SOF_A);
        frame_byte(SOF_B);
        frame_byte(c);
      end else if (kind < 83) begin
        // bad end bytes
        e0 = END_A;
        e1 = END_B;
        if ($urandom_range(1)) begin
          do e0 = 8'($urandom_range(255)); while (e0 == END_A);
          e1 = 8'($urandom_range(255));
        end else begin
          do e1 = 8'($urandom_range(255)); while (e1 == END_B);
        end
        feed_frame(pick_short_op(), 1'b0, e0, e1);
      end else if (kind < 91 && with_timeouts) begin
        // stall inside a frame until the byte timeout fires
        frame_byte(SOF_A);
        depth = $urandom_range(2);
        if (depth >= 1) frame_byte(SOF_B);
        if (depth >= 2) begin
          op = $urandom_range(1) ? OP_WRITE : pick_short_op();
          frame_byte(op);
          if (op == OP_WRITE) repeat ($urandom_range(6)) frame_byte(8'($urandom_range(255)));
          else if ($urandom_range(1)) frame_byte(END_A);
        end
        repeat (int'(timeout_lim)) feed(1'b1, 8'($urandom_range(255)));
        repeat ($urandom_range(2)) feed(1'b1, 8'($urandom_range(255)));
      end else begin
        // line noise and ticks while idle
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(1)) begin
            feed(1'b1, 8'($urandom_range(255)));
          end else begin
            do c = 8'($urandom_range(255)); while (c == SOF_A);
            feed(1'b0, c);
          end
        end
      end
    end
  endtask

  // Let all replies drain, then write the timeout register
  task automatic settle_then_config(input logic [15:0] ticks);
    push <= 1'b0;
    while (reply_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_lim = ticks;
  endtask

  function automatic script_row_t rx_row(input logic [7:0] b);
    return '{1'b0, b, 1'b0, '0};
  endfunction

  // Closing byte of a short command, with its five-byte ack typed in
  function automatic script_row_t ack_row(input logic [7:0] op);
    return '{1'b0, END_B, 1'b1, '{{24'h0, END_B, END_A, op, SOF_B, SOF_A}, 4'd5, 1'b1, 1'b0}};
  endfunction

  // ------------------------------------------------------------ main flow
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    push         <= 1'b0;
    in_mode      <= 1'b0;
    in_rx_byte   <= '0;
    items_fed    = 0;
    hold_pop_req = 1'b0;
    timeout_lim  = TIMEOUT_RESET;
    foreach (bank_mem[i]) bank_mem[i] = '0;
    live_bank  = 1'b0;
    staged     = 1'b0;
    parse_st   = PS_IDLE;
    cur_op     = '0;
    pay_idx    = 0;
    end_a_byte = '0;
    tick_cnt   = '0;

    script = '{
      '{1'b1, 8'h5A, 1'b0, '0},                     // tick while idle
      rx_row(8'h00), rx_row(8'hFF),                 // idle bytes ignored
      rx_row(SOF_A), rx_row(SOF_B), rx_row(OP_COMMIT), rx_row(END_A),
      ack_row(OP_COMMIT),                           // commit with nothing staged
      rx_row(SOF_A), rx_row(SOF_B), rx_row(OP_ABORT), rx_row(END_A),
      ack_row(OP_ABORT),
      rx_row(SOF_A), rx_row(8'h00),                 // wrong second start byte
      rx_row(SOF_A), rx_row(SOF_B), rx_row(8'hFF),  // unknown command
      rx_row(SOF_A), rx_row(SOF_B), rx_row(OP_READ), rx_row(END_A),
      rx_row(END_B),                                // read of the zeroed bank
      rx_row(SOF_A), rx_row(SOF_B), rx_row(OP_ABORT), rx_row(END_A),
      rx_row(8'h00)                                 // bad end bytes
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset timeout
    foreach (script[i]) begin
      send_item(script[i].mode, script[i].rx);
      advance_loader(script[i].mode, script[i].rx);
      if (script[i].typed) reply_words.push_back(script[i].word);
      else foreach (fresh_words[j]) reply_words.push_back(fresh_words[j]);
      items_fed++;
    end

    // Shortest timeout: any tick inside a frame aborts it
    settle_then_config(16'd1);
    run_frames(items_fed + 50, 1'b1);

    // Mid-range timeout; stage and commit, then stall the reader under a long
    // read reply and short frames until the input backs up
    settle_then_config(16'($urandom_range(40, 2)));
    feed_frame(OP_WRITE, 1'b1, END_A, END_B);
    feed_frame(OP_COMMIT, 1'b0, END_A, END_B);
    hold_pop_req = 1'b1;
    feed_frame(OP_READ, 1'b0, END_A, END_B);
    feed_frame(OP_ABORT, 1'b0, END_A, END_B);
    feed_frame(OP_COMMIT, 1'b0, END_A, END_B);
    feed_frame(OP_ABORT, 1'b0, END_A, END_B);
    feed_frame(OP_COMMIT, 1'b0, END_A, END_B);
    run_frames(items_fed + 45, 1'b1);

    // Longest timeout
    settle_then_config(16'hFFFF);
    run_frames(items_fed + 45, 1'b0);

    push <= 1'b0;
    while (reply_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (word_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // ------------------------------------------------------------- replies
  task automatic check_word();
    out_item_t exp_w;
    if (reply_words.size() == 0) begin
      word_errors++;
      if (word_errors <= 10)
        $display("reply word with none pending: data=%h count=%0d last=%b pulse=%b",
                 out_tx_data, out_tx_count, out_tx_last, out_commit_pulse);
      return;
    end
    exp_w = reply_words.pop_front();
    if (exp_w.data !== out_tx_data || exp_w.count !== out_tx_count ||
        exp_w.last !== out_tx_last || exp_w.pulse !== out_commit_pulse) begin
      word_errors++;
      if (word_errors <= 10)
        $display("reply mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                 exp_w.data, exp_w.count, exp_w.last, exp_w.pulse,
                 out_tx_data, out_tx_count, out_tx_last, out_commit_pulse);
    end
  endtask

  // Pop with random gaps; hold off once for a long stretch when asked
  initial begin
    bit held;
    held = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_word();
      if (hold_pop_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (POP_HOLD_CYCLES) @(posedge clk);
      end
      pop <= steady_window() || $urandom_range(99) >= 29;
    end
  end

  // Abort when neither side has moved a request for too long
  initial begin
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

endmodule
